FILE: sv/xte_pkg.sv
// Shared types and constants for the XML text escaper with UTF-8 filter.
package xte_pkg;

  // Longest escape sequence ("&quot;") sets the run length.
  localparam int unsigned RUN_MAX = 6;

  // One input byte's worth of output: len bytes taken from bytes[0] upward.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              len;
  } xte_run_t;

endpackage

FILE: sv/xte_in_if.sv
// Input channel: one raw text byte and its attribute-context flag per transaction.
interface xte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       attribute_mode;

  modport source (output valid, output data_byte, output attribute_mode, input ready);
  modport sink   (input valid, input data_byte, input attribute_mode, output ready);
endinterface

FILE: sv/xte_out_if.sv
// Result channel: one escaped output byte and its end-of-run flag per transaction.
interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: sv/xte_front.sv
// Front end: accepts text bytes, tracks UTF-8 sequences and builds escaped output runs.
module xte_front (
  input  logic             clk,
  input  logic             rst_n,
  xte_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             q_push,
  output xte_pkg::xte_run_t q_run
);
  import xte_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  logic [2:0][7:0] carry_r, carry_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [1:0]      need_r, need_nxt;

  logic            accept;
  logic [7:0]      b;
  logic            attr;
  logic            is_cont;
  logic            c1_ok, c2_ok;
  logic [10:0]     cp2;
  logic [15:0]     cp3;
  logic [20:0]     cp4;
  logic            seq_good;
  logic            ctl_ok;
  logic            fresh;
  logic            emit;
  xte_run_t        run;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign attr        = in_ch.attribute_mode;
  assign is_cont     = (b[7:6] == 2'b10);
  assign c1_ok       = (carry_r[1][7:6] == 2'b10);
  assign c2_ok       = (carry_r[2][7:6] == 2'b10);
  assign ctl_ok      = (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);

  assign cp2 = {carry_r[0][4:0], b[5:0]};
  assign cp3 = {carry_r[0][3:0], carry_r[1][5:0], b[5:0]};
  assign cp4 = {carry_r[0][2:0], carry_r[1][5:0], carry_r[2][5:0], b[5:0]};

  // Well-formedness of the gathered sequence closed by this continuation byte.
  always_comb begin
    unique case (cnt_r)
      2'd1:    seq_good = (cp2 >= 11'h080);
      2'd2:    seq_good = c1_ok && (cp3 >= 16'h0800) &&
                          ((cp3 < 16'hD800) || (cp3 > 16'hDFFF));
      2'd3:    seq_good = c1_ok && c2_ok && (cp4 >= 21'h10000) &&
                          (cp4 <= 21'h10FFFF);
      default: seq_good = 1'b0;
    endcase
  end

  always_comb begin
    carry_nxt = carry_r;
    cnt_nxt   = cnt_r;
    need_nxt  = need_r;
    emit      = 1'b0;
    fresh     = 1'b0;
    run       = '0;

    if (need_r != 2'd0) begin
      if (!is_cont) begin
        // Cut short: drop the partial sequence and treat this byte as new.
        cnt_nxt  = 2'd0;
        need_nxt = 2'd0;
        fresh    = 1'b1;
      end else if (need_r > 2'd1) begin
        if (cnt_r != 2'd3) carry_nxt[cnt_r] = b;
        cnt_nxt  = cnt_r + 2'd1;
        need_nxt = need_r - 2'd1;
      end else begin
        run.bytes[2:0]  = carry_r;
        run.bytes[cnt_r] = b;
        run.len         = {1'b0, cnt_r} + 3'd1;
        emit            = seq_good;
        cnt_nxt         = 2'd0;
        need_nxt        = 2'd0;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (!b[7]) begin
        if (!((b < CH_SPACE && !ctl_ok) || b == CH_DEL)) begin
          emit = 1'b1;
          if (b == CH_AMP) begin
            run.bytes[4:0] = {CH_SEMI, CH_P, CH_M, CH_A, CH_AMP};
            run.len        = 3'd5;
          end else if (b == CH_LT) begin
            run.bytes[3:0] = {CH_SEMI, CH_T, CH_L, CH_AMP};
            run.len        = 3'd4;
          end else if (b == CH_GT) begin
            run.bytes[3:0] = {CH_SEMI, CH_T, CH_G, CH_AMP};
            run.len        = 3'd4;
          end else if (b == CH_QUOT && attr) begin
            run.bytes[5:0] = {CH_SEMI, CH_T, CH_O, CH_U, CH_Q, CH_AMP};
            run.len        = 3'd6;
          end else if (ctl_ok && attr) begin
            run.bytes[0] = CH_SPACE;
            run.len      = 3'd1;
          end else begin
            run.bytes[0] = b;
            run.len      = 3'd1;
          end
        end
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        carry_nxt[0] = b;
        cnt_nxt      = 2'd1;
        need_nxt     = 2'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        carry_nxt[0] = b;
        cnt_nxt      = 2'd1;
        need_nxt     = 2'd2;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        carry_nxt[0] = b;
        cnt_nxt      = 2'd1;
        need_nxt     = 2'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      need_r <= 2'd0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      need_r <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) carry_r <= carry_nxt;
  end

  assign q_push = accept && emit;
  assign q_run  = run;

endmodule

FILE: sv/xte_fifo.sv
// Small queue of output runs between the front end and the serializer.
module xte_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xte_pkg::xte_run_t push_run,
  output logic              full,
  input  logic              pop,
  output xte_pkg::xte_run_t head,
  output logic              empty
);
  import xte_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  xte_run_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_run;
  end

endmodule

FILE: sv/xte_serial.sv
// Back end: sends each queued run one byte per transaction and marks its last byte.
module xte_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  xte_pkg::xte_run_t head,
  input  logic              empty,
  output logic              pop,
  xte_out_if.source         out_ch
);
  import xte_pkg::*;

  logic [2:0] idx_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       valid_r;
  logic       load;
  logic       at_last;

  assign load    = !empty && (!valid_r || out_ch.ready);
  assign at_last = (3'(idx_r + 3'd1) == head.len);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 3'd0 : idx_r + 3'd1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Hold the payload while the receiver stalls.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      last_r <= at_last;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.last_of_run = last_r;

endmodule

FILE: sv/xml_text_escaper_utf8_filter.sv
// Top level of the XML text escaper with UTF-8 filter.
// Usage:
//   in_ch takes one raw text byte per transaction with its attribute_mode flag.
//   out_ch gives the escaped text one byte per transaction; last_of_run marks
//   the final byte produced by one input byte. Input bytes that are dropped,
//   or that only extend a pending UTF-8 sequence, produce no output.
// Path: an accepted byte's run is written into the run queue, then loaded
//   into the output register, from which its first output byte is sent.
// Throughput: the front end accepts one byte per cycle while the run queue
//   has room; the serializer sends one output byte per cycle while out_ch.ready
//   is high, and an escaped double quote expands to six output bytes.
//   Sustained rate is one input byte per cycle for text that needs no escaping
//   while out_ch.ready stays high.
// Reset: rst_n clears the pending UTF-8 sequence, the queue and the output
//   valid flag; no clearing pass is needed.
// Stall: when out_ch.ready is low the output byte holds, the queue fills and
//   in_ch.ready drops once QUEUE_DEPTH runs are waiting.
module xml_text_escaper_utf8_filter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  xte_in_if.sink    in_ch,
  xte_out_if.source out_ch
);
  import xte_pkg::*;

  xte_run_t push_run;
  xte_run_t head;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  xte_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_run  (push_run)
  );

  xte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  xte_serial u_serial (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
